// File: hdl/v3alu_pkg.sv
// Shared types, widths, codes and the saturation helper for the vector ALU.
// No dependencies; every other file in hdl/ imports this package.
package v3alu_pkg;

  // Field and datapath widths
  localparam int FixW      = 32;            // Q16.16 component
  localparam int FracW     = 16;            // fraction bits
  localparam int ProdW     = 2 * FixW;      // exact Q32.32 product
  localparam int SumW      = ProdW + 2;     // sum of three products plus rounding
  localparam int SatInW    = SumW - FracW;  // rounded sum before saturation
  localparam int SqrtSteps = FixW;          // one root bit per stage
  localparam int RemW      = FixW + 2;      // square-root remainder
  localparam int LenW      = FixW + 1;      // rounded length
  localparam int DivSteps  = FracW + 1;     // quotient bits of a unit component
  localparam int NumW      = ProdW - FracW + 2;  // dividend and remainder width

  // Stream widths
  localparam int DataInW  = 6 * FixW;
  localparam int UserInW  = 3;
  localparam int DataOutW = 4 * FixW;
  localparam int UserOutW = 2;

  // Action codes on the input side
  localparam logic [UserInW-1:0] ACT_ADD   = 3'd0;
  localparam logic [UserInW-1:0] ACT_SUB   = 3'd1;
  localparam logic [UserInW-1:0] ACT_NEG   = 3'd2;
  localparam logic [UserInW-1:0] ACT_DOT   = 3'd3;
  localparam logic [UserInW-1:0] ACT_CROSS = 3'd4;
  localparam logic [UserInW-1:0] ACT_NORM  = 3'd5;

  localparam logic [FixW-1:0] FIX_MAX = {1'b0, {(FixW-1){1'b1}}};
  localparam logic [FixW-1:0] FIX_MIN = {1'b1, {(FixW-1){1'b0}}};
  localparam logic signed [SumW-1:0] ROUND_HALF = SumW'(1) << (FracW - 1);

  // Operation class after decode
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_NEG   = 3'd3,
    OP_DOT   = 3'd4,
    OP_CROSS = 3'd5,
    OP_NORM  = 3'd6
  } op_e;

  typedef logic [2:0][FixW-1:0] vec_t;

  typedef struct packed {
    op_e  op;
    vec_t a;
    vec_t b;
  } item_t;

  typedef struct packed {
    vec_t            r;
    logic [FixW-1:0] sc;
    logic            ov;
    logic            zl;
  } result_t;

  typedef struct packed {
    logic [FixW-1:0] v;
    logic            ov;
  } sat_t;

  // Clamp a signed value to the 32-bit range and flag the clamp
  function automatic sat_t sat_fix(input logic [SatInW-1:0] v);
    sat_t res;
    res.ov = !((&v[SatInW-1:FixW-1]) || (~|v[SatInW-1:FixW-1]));
    if (res.ov) begin
      res.v = v[SatInW-1] ? FIX_MIN : FIX_MAX;
    end else begin
      res.v = v[FixW-1:0];
    end
    return res;
  endfunction

endpackage

// File: hdl/v3alu_front.sv
// Front end: takes input transfers, decodes the action code into an operation class
// and hands the item to the queue. Depends on v3alu_pkg.
module v3alu_front (
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z from bit 0 up
  input  logic [v3alu_pkg::DataInW-1:0]      s_axis_tdata,
  // action
  input  logic [v3alu_pkg::UserInW-1:0]      s_axis_tuser,
  input  logic                               queue_full_i,
  output logic                               push_o,
  output v3alu_pkg::item_t                   item_o
);
  import v3alu_pkg::*;

  // Accept whenever the queue has room
  assign s_axis_tready = !queue_full_i;
  assign push_o        = s_axis_tvalid && !queue_full_i;

  // Classify the action code; unused codes give an all-zero result
  always_comb begin
    item_o.a = s_axis_tdata[3*FixW-1:0];
    item_o.b = s_axis_tdata[6*FixW-1:3*FixW];
    case (s_axis_tuser)
      ACT_ADD:   item_o.op = OP_ADD;
      ACT_SUB:   item_o.op = OP_SUB;
      ACT_NEG:   item_o.op = OP_NEG;
      ACT_DOT:   item_o.op = OP_DOT;
      ACT_CROSS: item_o.op = OP_CROSS;
      ACT_NORM:  item_o.op = OP_NORM;
      default:   item_o.op = OP_NONE;
    endcase
  end

endmodule

// File: hdl/v3alu_queue.sv
// Short FIFO of decoded items between front end and execution pipeline.
// Depends on v3alu_pkg for the item type.
module v3alu_queue #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  v3alu_pkg::item_t item_i,
  output logic             full_o,
  output logic             valid_o,
  output v3alu_pkg::item_t item_o,
  input  logic             pop_i
);
  import v3alu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: hdl/v3alu_back.sv
// Execution pipeline: multiply, sum and round, saturate, 32-stage square root,
// 17-stage divider per lane, output register. Depends on v3alu_pkg.
module v3alu_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           head_valid_i,
  input  v3alu_pkg::item_t               head_i,
  output logic                           pop_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // r_x, r_y, r_z, r_scalar from bit 0 up
  output logic [v3alu_pkg::DataOutW-1:0] m_axis_tdata,
  // overflow, zero_length from bit 0 up
  output logic [v3alu_pkg::UserOutW-1:0] m_axis_tuser
);
  import v3alu_pkg::*;

  typedef struct packed {
    logic    norm;
    result_t res;
    vec_t    a;
  } carry_t;

  localparam int NextIdx [3] = '{1, 2, 0};
  localparam int PrevIdx [3] = '{2, 0, 1};

  // The whole pipeline moves together when the output register frees up
  logic adv;
  logic out_vld_q;
  result_t out_res_q, out_res_d;

  assign adv   = !out_vld_q || m_axis_tready;
  assign pop_o = adv && head_valid_i;

  // ---------------- stage A: products and simple vector ops
  logic                    a_vld_q;
  op_e                     a_op_q;
  logic signed [ProdW-1:0] pa_q [3], pa_d [3];
  logic signed [ProdW-1:0] pb_q [3], pb_d [3];
  result_t                 a_pre_q, a_pre_d;
  vec_t                    a_vec_q;
  logic signed [FixW-1:0]  mx [3], my [3], mu [3], mv [3];
  logic [FixW:0]           s33 [3];
  sat_t                    sat_a [3];

  always_comb begin
    a_pre_d = '0;
    for (int i = 0; i < 3; i++) begin
      mx[i] = $signed(head_i.a[i]);
      my[i] = $signed(head_i.b[i]);
      mu[i] = '0;
      mv[i] = '0;
      case (head_i.op)
        OP_CROSS: begin
          mx[i] = $signed(head_i.a[NextIdx[i]]);
          my[i] = $signed(head_i.b[PrevIdx[i]]);
          mu[i] = $signed(head_i.a[PrevIdx[i]]);
          mv[i] = $signed(head_i.b[NextIdx[i]]);
        end
        OP_NORM: begin
          my[i] = $signed(head_i.a[i]);
        end
        default: ;
      endcase
      pa_d[i] = mx[i] * my[i];
      pb_d[i] = mu[i] * mv[i];

      case (head_i.op)
        OP_ADD:  s33[i] = {head_i.a[i][FixW-1], head_i.a[i]}
                          + {head_i.b[i][FixW-1], head_i.b[i]};
        OP_SUB:  s33[i] = {head_i.a[i][FixW-1], head_i.a[i]}
                          - {head_i.b[i][FixW-1], head_i.b[i]};
        OP_NEG:  s33[i] = (FixW+1)'(0) - {head_i.a[i][FixW-1], head_i.a[i]};
        default: s33[i] = '0;
      endcase
      sat_a[i]       = sat_fix({{(SatInW-FixW-1){s33[i][FixW]}}, s33[i]});
      a_pre_d.r[i]   = sat_a[i].v;
      a_pre_d.ov     = a_pre_d.ov | sat_a[i].ov;
    end
  end

  // ---------------- stage B: sums of products with the rounding term
  logic                    b_vld_q;
  op_e                     b_op_q;
  logic signed [SumW-1:0]  dsum_q, dsum_d;
  logic signed [SumW-1:0]  csum_q [3], csum_d [3];
  logic [ProdW-1:0]        nsum_q, nsum_d;
  result_t                 b_pre_q;
  vec_t                    b_vec_q;

  always_comb begin
    dsum_d = SumW'(pa_q[0]) + SumW'(pa_q[1]) + SumW'(pa_q[2]) + ROUND_HALF;
    nsum_d = pa_q[0][ProdW-1:0] + pa_q[1][ProdW-1:0] + pa_q[2][ProdW-1:0];
    for (int i = 0; i < 3; i++) begin
      csum_d[i] = SumW'(pa_q[i]) - SumW'(pb_q[i]) + ROUND_HALF;
    end
  end

  // ---------------- stage C: saturate, select result, seed the square root
  sat_t   dsat;
  sat_t   csat [3];
  carry_t c_carry;

  always_comb begin
    dsat          = sat_fix(dsum_q[SumW-1:FracW]);
    c_carry.norm  = (b_op_q == OP_NORM);
    c_carry.a     = b_vec_q;
    c_carry.res   = '0;
    for (int i = 0; i < 3; i++) begin
      csat[i] = sat_fix(csum_q[i][SumW-1:FracW]);
    end
    case (b_op_q)
      OP_ADD, OP_SUB, OP_NEG: c_carry.res = b_pre_q;
      OP_DOT: begin
        c_carry.res.sc = dsat.v;
        c_carry.res.ov = dsat.ov;
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          c_carry.res.r[i] = csat[i].v;
        end
        c_carry.res.ov = csat[0].ov | csat[1].ov | csat[2].ov;
      end
      OP_NORM:  c_carry.res.zl = (nsum_q == '0);
      default:  ;
    endcase
  end

  // ---------------- square root, one root bit per stage
  logic                sq_vld_q  [SqrtSteps+1], sq_vld_d  [SqrtSteps+1];
  logic [RemW-1:0]     sq_rem_q  [SqrtSteps+1], sq_rem_d  [SqrtSteps+1];
  logic [FixW-1:0]     sq_root_q [SqrtSteps+1], sq_root_d [SqrtSteps+1];
  logic [ProdW-1:0]    sq_v_q    [SqrtSteps+1], sq_v_d    [SqrtSteps+1];
  carry_t              sq_c_q    [SqrtSteps+1], sq_c_d    [SqrtSteps+1];
  logic [RemW+1:0]     sq_cur    [SqrtSteps];
  logic [RemW+1:0]     sq_trial  [SqrtSteps];
  logic                sq_take   [SqrtSteps];

  always_comb begin
    sq_vld_d[0]  = b_vld_q;
    sq_rem_d[0]  = '0;
    sq_root_d[0] = '0;
    sq_v_d[0]    = nsum_q;
    sq_c_d[0]    = c_carry;
    for (int s = 0; s < SqrtSteps; s++) begin
      sq_cur[s]      = {sq_rem_q[s], sq_v_q[s][ProdW-1 -: 2]};
      sq_trial[s]    = {2'b00, sq_root_q[s], 2'b01};
      sq_take[s]     = (sq_cur[s] >= sq_trial[s]);
      sq_vld_d[s+1]  = sq_vld_q[s];
      sq_rem_d[s+1]  = sq_take[s] ? RemW'(sq_cur[s] - sq_trial[s]) : sq_cur[s][RemW-1:0];
      sq_root_d[s+1] = {sq_root_q[s][FixW-2:0], sq_take[s]};
      sq_v_d[s+1]    = {sq_v_q[s][ProdW-3:0], 2'b00};
      sq_c_d[s+1]    = sq_c_q[s];
    end
  end

  // ---------------- length rounding and divider seed
  logic [LenW-1:0] len;
  logic [FixW-1:0] mag [3];
  logic            len_sat;
  carry_t          r_carry;

  always_comb begin
    len     = LenW'(sq_root_q[SqrtSteps])
              + LenW'(sq_rem_q[SqrtSteps] > RemW'(sq_root_q[SqrtSteps]));
    len_sat = len[LenW-1] | len[LenW-2];
    r_carry = sq_c_q[SqrtSteps];
    if (r_carry.norm && !r_carry.res.zl) begin
      r_carry.res.sc = len_sat ? FIX_MAX : len[FixW-1:0];
      r_carry.res.ov = len_sat;
    end
    for (int i = 0; i < 3; i++) begin
      mag[i] = r_carry.a[i][FixW-1] ? FixW'(0) - r_carry.a[i] : r_carry.a[i];
    end
  end

  // ---------------- restoring divider, one quotient bit per stage
  logic                 dv_vld_q [DivSteps+1], dv_vld_d [DivSteps+1];
  logic [LenW-1:0]      dv_len_q [DivSteps+1], dv_len_d [DivSteps+1];
  logic [NumW-1:0]      dv_rem_q [DivSteps+1][3], dv_rem_d [DivSteps+1][3];
  logic [DivSteps-1:0]  dv_quo_q [DivSteps+1][3], dv_quo_d [DivSteps+1][3];
  carry_t               dv_c_q   [DivSteps+1], dv_c_d   [DivSteps+1];
  logic [NumW-1:0]      dv_div   [DivSteps];

  always_comb begin
    dv_vld_d[0] = sq_vld_q[SqrtSteps];
    dv_len_d[0] = len;
    dv_c_d[0]   = r_carry;
    for (int i = 0; i < 3; i++) begin
      dv_rem_d[0][i] = NumW'({mag[i], {FracW{1'b0}}}) + NumW'(len >> 1);
      dv_quo_d[0][i] = '0;
    end
    for (int t = 0; t < DivSteps; t++) begin
      dv_div[t]     = NumW'(dv_len_q[t]) << (DivSteps - 1 - t);
      dv_vld_d[t+1] = dv_vld_q[t];
      dv_len_d[t+1] = dv_len_q[t];
      dv_c_d[t+1]   = dv_c_q[t];
      for (int i = 0; i < 3; i++) begin
        dv_quo_d[t+1][i] = dv_quo_q[t][i];
        if (dv_rem_q[t][i] >= dv_div[t]) begin
          dv_rem_d[t+1][i] = dv_rem_q[t][i] - dv_div[t];
          dv_quo_d[t+1][i][DivSteps-1-t] = 1'b1;
        end else begin
          dv_rem_d[t+1][i] = dv_rem_q[t][i];
        end
      end
    end
  end

  // ---------------- apply signs and form the output
  always_comb begin
    out_res_d = dv_c_q[DivSteps].res;
    if (dv_c_q[DivSteps].norm && !dv_c_q[DivSteps].res.zl) begin
      for (int i = 0; i < 3; i++) begin
        out_res_d.r[i] = dv_c_q[DivSteps].a[i][FixW-1]
                         ? FixW'(0) - FixW'(dv_quo_q[DivSteps][i])
                         : FixW'(dv_quo_q[DivSteps][i]);
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      sq_vld_q  <= '{default: 1'b0};
      dv_vld_q  <= '{default: 1'b0};
      out_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q   <= head_valid_i;
      b_vld_q   <= a_vld_q;
      sq_vld_q  <= sq_vld_d;
      dv_vld_q  <= dv_vld_d;
      out_vld_q <= dv_vld_q[DivSteps];
    end
  end

  // Payload, held while the output stalls
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_op_q    <= head_i.op;
      pa_q      <= pa_d;
      pb_q      <= pb_d;
      a_pre_q   <= a_pre_d;
      a_vec_q   <= head_i.a;
      b_op_q    <= a_op_q;
      dsum_q    <= dsum_d;
      csum_q    <= csum_d;
      nsum_q    <= nsum_d;
      b_pre_q   <= a_pre_q;
      b_vec_q   <= a_vec_q;
      sq_rem_q  <= sq_rem_d;
      sq_root_q <= sq_root_d;
      sq_v_q    <= sq_v_d;
      sq_c_q    <= sq_c_d;
      dv_len_q  <= dv_len_d;
      dv_rem_q  <= dv_rem_d;
      dv_quo_q  <= dv_quo_d;
      dv_c_q    <= dv_c_d;
      out_res_q <= out_res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_res_q.sc, out_res_q.r};
  assign m_axis_tuser  = {out_res_q.zl, out_res_q.ov};

endmodule

// File: hdl/vector3_fixed_point_alu.sv
// Top level of the Q16.16 three-component vector ALU.
// Instantiates v3alu_front, v3alu_queue and v3alu_back; depends on v3alu_pkg.
//
//   channel  | dir | tdata (bit 0 up)               | tuser (bit 0 up)
//   s_axis   | in  | a_x a_y a_z b_x b_y b_z (192b) | action (3b)
//   m_axis   | out | r_x r_y r_z r_scalar (128b)    | overflow zero_length (2b)
//
// One item per clock while the output is not stalled; every operation takes
// the same path from queue head to output register, through stages A, B and
// C, the 32-stage square root and the 17-stage divider used by normalize.
// Results leave in input order.
// Reset clears the valid bits and the queue; no clearing pass.
// A stalled output holds the pipeline; the queue keeps taking items until full.
module vector3_fixed_point_alu #(
  parameter int QueueDepth = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z from bit 0 up
  input  logic [v3alu_pkg::DataInW-1:0]  s_axis_tdata,
  // action
  input  logic [v3alu_pkg::UserInW-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // r_x, r_y, r_z, r_scalar from bit 0 up
  output logic [v3alu_pkg::DataOutW-1:0] m_axis_tdata,
  // overflow, zero_length from bit 0 up
  output logic [v3alu_pkg::UserOutW-1:0] m_axis_tuser
);
  import v3alu_pkg::*;

  logic  push, full, head_valid, pop;
  item_t push_item, head_item;

  v3alu_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_full_i  (full),
    .push_o        (push),
    .item_o        (push_item)
  );

  v3alu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .valid_o (head_valid),
    .item_o  (head_item),
    .pop_i   (pop)
  );

  v3alu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
